FILE: rtl/core/rmq_pkg.sv
// package for rotation matrix to quaternion: constants and shared widths
`timescale 1ns / 1ps
package rmq_pkg;
   localparam int FRAC_BITS_DEF = 14;
   localparam int FIELD_W = 16;
   localparam int OUT_MAX = 32767;
endpackage

FILE: rtl/core/rmq_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module rmq_isqrt #(
   parameter int IN_W = 32,
   parameter int TAG_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [IN_W-1:0]      in_value,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [(IN_W+1)/2-1:0] out_root,
   output logic [TAG_W-1:0]     out_tag
);
   localparam int RW = (IN_W + 1) / 2;
   localparam int VW = 2 * RW;

   logic [VW-1:0]    rem_ff  [RW];
   logic [RW-1:0]    root_ff [RW];
   logic [TAG_W-1:0] tag_ff  [RW];
   logic [RW-1:0]    vld_ff;
   logic [VW-1:0]    rem_in  [RW];
   logic [RW-1:0]    root_in [RW];

   // stage s settles result bit RW-1-s
   always_comb begin
      logic [VW-1:0] rem_cur;
      logic [VW-1:0] trial;
      logic [RW-1:0] root_cur;
      rem_cur  = VW'(in_value);
      root_cur = '0;
      for (int s = 0; s < RW; s++) begin
         trial      = (VW'(root_cur) << (RW - s)) | (VW'(1) << (2 * (RW - 1 - s)));
         rem_in[s]  = rem_cur;
         root_in[s] = root_cur;
         if (rem_cur >= trial) begin
            rem_in[s]  = rem_cur - trial;
            root_in[s] = root_cur | (RW'(1) << (RW - 1 - s));
         end
         rem_cur  = rem_ff[s];
         root_cur = root_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RW-2:0], in_valid};
      end
      if (en) begin
         rem_ff    <= rem_in;
         root_ff   <= root_in;
         tag_ff[0] <= in_tag;
         for (int s = 1; s < RW; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];
endmodule

FILE: rtl/core/rmq_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module rmq_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);
   localparam int RW = DEN_W + 1;

   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [RW-1:0]    rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];
   logic [NUM_W-1:0] vld_ff;
   logic [NUM_W-1:0] num_in [NUM_W];
   logic [RW-1:0]    rem_in [NUM_W];

   always_comb begin
      logic [NUM_W-1:0] num_cur;
      logic [RW-1:0]    rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [RW:0]      sh;
      num_cur = in_num;
      rem_cur = '0;
      den_cur = in_den;
      for (int s = 0; s < NUM_W; s++) begin
         sh        = {rem_cur, num_cur[NUM_W-1]};
         num_in[s] = num_cur << 1;
         rem_in[s] = sh[RW-1:0];
         if (sh >= (RW+1)'(den_cur)) begin
            rem_in[s]    = RW'(sh - (RW+1)'(den_cur));
            num_in[s][0] = 1'b1;
         end
         num_cur = num_ff[s];
         rem_cur = rem_ff[s];
         den_cur = den_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NUM_W-2:0], in_valid};
      end
      if (en) begin
         num_ff    <= num_in;
         rem_ff    <= rem_in;
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
         for (int s = 1; s < NUM_W; s++) begin
            den_ff[s] <= den_ff[s-1];
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo   = num_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];
endmodule

FILE: rtl/core/rotation_matrix_to_quaternion.sv
// top level: rotation matrix to unit quaternion pipeline
// One matrix is taken every cycle while the result side is not stalled. Each quaternion
// passes a sum stage, a pipelined square root of the four diagonal terms (one stage per
// root bit), a squaring stage, a square-sum stage, a second square root for the length,
// a numerator stage, then four parallel pipelined dividers (one stage per quotient bit)
// and a clamp and sign output register. At 14 fraction bits that is
// 1 + 16 + 1 + 1 + 17 + 1 + 31 + 1 registers; the root and quotient widths set the
// depth. A stall at the result side holds every stage in place and stalls the request
// side in the same cycle.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion
#(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [rmq_pkg::FIELD_W-1:0] req_elem_0,
   input  logic signed [rmq_pkg::FIELD_W-1:0] req_elem_1,
   input  logic signed [rmq_pkg::FIELD_W-1:0] req_elem_2,
   input  logic signed [rmq_pkg::FIELD_W-1:0] req_elem_4,
   input  logic signed [rmq_pkg::FIELD_W-1:0] req_elem_5,
   input  logic signed [rmq_pkg::FIELD_W-1:0] req_elem_6,
   input  logic signed [rmq_pkg::FIELD_W-1:0] req_elem_8,
   input  logic signed [rmq_pkg::FIELD_W-1:0] req_elem_9,
   input  logic signed [rmq_pkg::FIELD_W-1:0] req_elem_10,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [rmq_pkg::FIELD_W-1:0] rsp_quat_w,
   output logic signed [rmq_pkg::FIELD_W-1:0] rsp_quat_x,
   output logic signed [rmq_pkg::FIELD_W-1:0] rsp_quat_y,
   output logic signed [rmq_pkg::FIELD_W-1:0] rsp_quat_z
);
   import rmq_pkg::*;

   localparam int SW = ((FRAC_BITS > FIELD_W) ? FRAC_BITS : FIELD_W) + 3; // signed diagonal sum
   localparam int SQ_IN = SW - 1 + FRAC_BITS;    // clamped sum shifted
   localparam int TW = (SQ_IN + 1) / 2;          // root width
   localparam int R2W = 2 * TW + 2;
   localparam int RW = (R2W + 1) / 2;
   localparam int NW = TW + FRAC_BITS + 1;
   localparam int EPS2 = int'(((64'd1 << (FRAC_BITS + 1)) + 64'd500) / 64'd1000);
   localparam int LIM = ((2 ** FRAC_BITS) > OUT_MAX) ? OUT_MAX : (2 ** FRAC_BITS);

   logic en;
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage 1: diagonal sums and sign tests
   logic signed [SW-1:0] one_s, d0, d1, d2, d3;
   logic signed [FIELD_W:0] a1, a2, a3, b2, b3, c3;
   logic [5:0] sgn_in;
   assign one_s = SW'(2 ** FRAC_BITS);
   always_comb begin
      d0 = SW'(req_elem_0) + SW'(req_elem_5) + SW'(req_elem_10) + one_s;
      d1 = SW'(req_elem_0) - SW'(req_elem_5) - SW'(req_elem_10) + one_s;
      d2 = -SW'(req_elem_0) + SW'(req_elem_5) - SW'(req_elem_10) + one_s;
      d3 = -SW'(req_elem_0) - SW'(req_elem_5) + SW'(req_elem_10) + one_s;
      a1 = (FIELD_W+1)'(req_elem_6) - (FIELD_W+1)'(req_elem_9);
      a2 = (FIELD_W+1)'(req_elem_8) - (FIELD_W+1)'(req_elem_2);
      a3 = (FIELD_W+1)'(req_elem_1) - (FIELD_W+1)'(req_elem_4);
      b2 = (FIELD_W+1)'(req_elem_1) + (FIELD_W+1)'(req_elem_4);
      b3 = (FIELD_W+1)'(req_elem_8) + (FIELD_W+1)'(req_elem_2);
      c3 = (FIELD_W+1)'(req_elem_6) + (FIELD_W+1)'(req_elem_9);
      sgn_in = {c3[FIELD_W], b3[FIELD_W], b2[FIELD_W],
                a3[FIELD_W], a2[FIELD_W], a1[FIELD_W]};
   end

   logic [SQ_IN-1:0] sq_ff [4];
   logic [5:0]       sgn_ff;
   logic             s1_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
      if (en) begin
         sq_ff[0] <= d0[SW-1] ? '0 : SQ_IN'(d0[SW-2:0]) << FRAC_BITS;
         sq_ff[1] <= d1[SW-1] ? '0 : SQ_IN'(d1[SW-2:0]) << FRAC_BITS;
         sq_ff[2] <= d2[SW-1] ? '0 : SQ_IN'(d2[SW-2:0]) << FRAC_BITS;
         sq_ff[3] <= d3[SW-1] ? '0 : SQ_IN'(d3[SW-2:0]) << FRAC_BITS;
         sgn_ff   <= sgn_in;
      end
   end

   // component roots
   logic [TW-1:0] t_root [4];
   logic [5:0]    t_sgn [4];
   logic          t_vld [4];
   for (genvar i = 0; i < 4; i++) begin : g_root
      rmq_isqrt #(.IN_W(SQ_IN), .TAG_W(6)) u_root (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(s1_vld_ff), .in_value(sq_ff[i]), .in_tag(sgn_ff),
         .out_valid(t_vld[i]), .out_root(t_root[i]), .out_tag(t_sgn[i])
      );
   end

   // stage: epsilon case, zeroing, squares
   logic lo0, lo1;
   logic [TW-1:0] tz [4];
   logic [3:0] neg_in;
   always_comb begin
      lo0 = t_root[0] < TW'(EPS2);
      lo1 = t_root[1] < TW'(EPS2);
      tz[0] = t_root[0];
      tz[1] = t_root[1];
      tz[2] = t_root[2];
      tz[3] = t_root[3];
      neg_in = 4'b0000;
      if (lo0 && lo1) begin
         tz[0] = '0;
         tz[1] = '0;
         neg_in[3] = t_sgn[0][5];
      end else if (lo0) begin
         tz[0] = '0;
         neg_in[2] = t_sgn[0][3];
         neg_in[3] = t_sgn[0][4];
      end else begin
         neg_in[1] = t_sgn[0][0];
         neg_in[2] = t_sgn[0][1];
         neg_in[3] = t_sgn[0][2];
      end
   end

   logic [TW-1:0]      tz_ff [4];
   logic [2*TW-1:0]    sqr_ff [4];
   logic [3:0]         neg_ff;
   logic               s3_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= t_vld[0];
      end
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            tz_ff[i]  <= tz[i];
            sqr_ff[i] <= (2*TW)'(tz[i]) * (2*TW)'(tz[i]);
         end
         neg_ff <= neg_in;
      end
   end

   // stage: sum of squares
   logic [R2W-1:0] r2_ff;
   logic [TW-1:0]  tz2_ff [4];
   logic [3:0]     neg2_ff;
   logic           s4_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
      if (en) begin
         r2_ff   <= R2W'(sqr_ff[0]) + R2W'(sqr_ff[1]) + R2W'(sqr_ff[2])
                    + R2W'(sqr_ff[3]);
         tz2_ff  <= tz_ff;
         neg2_ff <= neg_ff;
      end
   end

   // length root, components carried as tag
   localparam int TAGW = 4 * TW + 4;
   logic [RW-1:0]   r_root;
   logic [TAGW-1:0] r_tag;
   logic            r_vld;
   rmq_isqrt #(.IN_W(R2W), .TAG_W(TAGW)) u_len (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s4_vld_ff), .in_value(r2_ff),
      .in_tag({neg2_ff, tz2_ff[3], tz2_ff[2], tz2_ff[1], tz2_ff[0]}),
      .out_valid(r_vld), .out_root(r_root), .out_tag(r_tag)
   );

   // numerators with rounding term
   logic [NW-1:0] num_ff [4];
   logic [RW-1:0] den_ff;
   logic [3:0]    neg3_ff;
   logic          s5_vld_ff;
   logic [RW-1:0] r_nz;
   assign r_nz = (r_root == '0) ? RW'(1) : r_root;
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= r_vld;
      end
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            num_ff[i] <= (NW'(r_tag[i*TW +: TW]) << FRAC_BITS) + NW'(r_nz >> 1);
         end
         den_ff  <= r_nz;
         neg3_ff <= r_tag[4*TW +: 4];
      end
   end

   logic [NW-1:0] quo [4];
   logic [3:0]    q_neg [4];
   logic          q_vld [4];
   for (genvar i = 0; i < 4; i++) begin : g_div
      rmq_div #(.NUM_W(NW), .DEN_W(RW), .TAG_W(4)) u_div (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(s5_vld_ff), .in_num(num_ff[i]), .in_den(den_ff),
         .in_tag(neg3_ff),
         .out_valid(q_vld[i]), .out_quo(quo[i]), .out_tag(q_neg[i])
      );
   end

   // output register: clamp and sign
   logic [FIELD_W-1:0] res_in [4];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         res_in[i] = (quo[i] > NW'(LIM)) ? FIELD_W'(LIM) : quo[i][FIELD_W-1:0];
         if (q_neg[0][i]) begin
            res_in[i] = -res_in[i];
         end
      end
   end

   logic               out_vld_ff;
   logic [FIELD_W-1:0] out_ff [4];
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= q_vld[0];
      end
      if (en) begin
         out_ff <= res_in;
      end
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_quat_w = out_ff[0];
   assign rsp_quat_x = out_ff[1];
   assign rsp_quat_y = out_ff[2];
   assign rsp_quat_z = out_ff[3];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_w))
      else $error("result lost under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("stall without pending result");
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      q_vld[0] == q_vld[3])
      else $error("divider lanes out of step");
endmodule
